// ===== rtl/core/rdr_pkg.sv =====
// Shared types, widths, register codes and saturation helpers for the radial remap.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package rdr_pkg;

	localparam int PIX_W     = 12;  // integer pixel coordinate
	localparam int CTR_W     = 20;  // centre, unsigned Q12.8
	localparam int INVF_W    = 24;  // reciprocal focal, unsigned Q0.24
	localparam int COEF_W    = 24;  // radial coefficient, signed Q3.20
	localparam int SIDE_W    = 13;  // image side in pixels
	localparam int CRD_W     = 24;  // source coordinate, signed Q15.8
	localparam int DIFF_W    = 21;  // centred offset, signed Q.8
	localparam int R2_W      = 27;  // squared radius, unsigned Q.20
	localparam int POLY_W    = 32;  // polynomial value, signed Q.20
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	localparam int NUM_TERMS_DEF = 3;
	localparam int MAX_SIDE_DEF  = 4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_INV_FOCAL,
		REG_COEF_K1,
		REG_COEF_K2,
		REG_COEF_K3,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	// Per-item data that rides along with the radius and polynomial.
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [PIX_W-1:0]         pix_x;
		logic [PIX_W-1:0]         pix_y;
	} side_t;

	// Register code of radial term i (0 is k1).
	function automatic cfg_reg_t coef_reg(input int term);
		cfg_reg_t code;
		unique case (term)
			1:       code = REG_COEF_K2;
			2:       code = REG_COEF_K3;
			default: code = REG_COEF_K1;
		endcase
		return code;
	endfunction

	function automatic logic signed [CRD_W-1:0] sat24(input logic signed [63:0] v);
		logic signed [CRD_W-1:0] r;
		if (v > 64'sd8388607)
			r = 24'sh7FFFFF;
		else if (v < -64'sd8388608)
			r = 24'sh800000;
		else
			r = v[CRD_W-1:0];
		return r;
	endfunction

	function automatic logic signed [POLY_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [POLY_W-1:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[POLY_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rdr_pix_if.sv =====
// Input channel: valid/ready handshake carrying one output pixel position.
// Depends on rdr_pkg for field widths.
`default_nettype none

interface rdr_pix_if;
	import rdr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rdr_src_if.sv =====
// Output channel: valid/ready handshake carrying the source position and inside flag.
// Depends on rdr_pkg for field widths.
`default_nettype none

interface rdr_src_if;
	import rdr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] src_x;
	logic signed [CRD_W-1:0] src_y;
	logic                    inside_res;

	modport source (output valid, src_x, src_y, inside_res, input ready);
	modport sink (input valid, src_x, src_y, inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rdr_front.sv =====
// Front end: centred offset, normalization by the reciprocal focal, squared radius.
// Five register stages, all advancing on adv. Depends on rdr_pkg.
`default_nettype none

module rdr_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      adv,
	input  wire logic                      in_valid,
	input  wire logic [rdr_pkg::PIX_W-1:0]  pixel_x,
	input  wire logic [rdr_pkg::PIX_W-1:0]  pixel_y,
	input  wire logic [rdr_pkg::CTR_W-1:0]  center_x,
	input  wire logic [rdr_pkg::CTR_W-1:0]  center_y,
	input  wire logic [rdr_pkg::INVF_W-1:0] inv_focal,
	output logic                           out_valid,
	output logic [rdr_pkg::R2_W-1:0]       r2,
	output rdr_pkg::side_t                 side
);
	import rdr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [45:0] mul_x_s2, mul_y_s2;
	logic signed [CRD_W-1:0] nu_s3, nv_s3;
	logic [46:0] sq_x_s4, sq_y_s4;
	logic [R2_W-1:0] r2_s5;

	logic signed [DIFF_W-1:0] dx_c, dy_c;
	logic signed [45:0] rnd_x_c, rnd_y_c, sh_x_c, sh_y_c;
	logic signed [47:0] pu_c, pv_c;
	logic [47:0] sum_c;

	assign dx_c = $signed({1'b0, pixel_x, 8'b0}) - $signed({1'b0, center_x});
	assign dy_c = $signed({1'b0, pixel_y, 8'b0}) - $signed({1'b0, center_y});

	// round half up, then floor shift by 12
	assign rnd_x_c = mul_x_s2 + 46'sd2048;
	assign rnd_y_c = mul_y_s2 + 46'sd2048;
	assign sh_x_c  = rnd_x_c >>> 12;
	assign sh_y_c  = rnd_y_c >>> 12;

	assign pu_c  = nu_s3 * nu_s3;
	assign pv_c  = nv_s3 * nv_s3;
	assign sum_c = {1'b0, sq_x_s4} + {1'b0, sq_y_s4} + 48'd524288;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.dx    <= dx_c;
			side_s1.dy    <= dy_c;
			side_s1.pix_x <= pixel_x;
			side_s1.pix_y <= pixel_y;

			mul_x_s2 <= $signed(side_s1.dx) * $signed({1'b0, inv_focal});
			mul_y_s2 <= $signed(side_s1.dy) * $signed({1'b0, inv_focal});
			side_s2  <= side_s1;

			nu_s3   <= sat24(64'(sh_x_c));
			nv_s3   <= sat24(64'(sh_y_c));
			side_s3 <= side_s2;

			sq_x_s4 <= pu_c[46:0];
			sq_y_s4 <= pv_c[46:0];
			side_s4 <= side_s3;

			r2_s5   <= sum_c[47] ? {R2_W{1'b1}} : sum_c[46:20];
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign r2        = r2_s5;
	assign side      = side_s5;

endmodule

`default_nettype wire

// ===== rtl/core/rdr_cell.sv =====
// One Horner step cell: holds its radial coefficient and computes
// p_out = sat32(round((p_in + k) * r2 / 2^20)) over three stages. Depends on rdr_pkg.
`default_nettype none

module rdr_cell (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire logic                             coef_we,
	input  wire logic [rdr_pkg::COEF_W-1:0]        coef_wdata,
	input  wire logic                             in_valid,
	input  wire logic signed [rdr_pkg::POLY_W-1:0] p_in,
	input  wire logic [rdr_pkg::R2_W-1:0]          r2_in,
	input  wire rdr_pkg::side_t                   side_in,
	output logic                                  out_valid,
	output logic signed [rdr_pkg::POLY_W-1:0]      p_out,
	output logic [rdr_pkg::R2_W-1:0]               r2_out,
	output rdr_pkg::side_t                        side_out
);
	import rdr_pkg::*;

	logic signed [COEF_W-1:0] coef_q;

	logic v_s1, v_s2, v_s3;
	logic signed [POLY_W:0] sum_s1;
	logic signed [60:0] prod_s2;
	logic signed [POLY_W-1:0] p_s3;
	logic [R2_W-1:0] r2_s1, r2_s2, r2_s3;
	side_t side_s1, side_s2, side_s3;

	logic signed [60:0] rnd_c, sh_c;

	assign rnd_c = prod_s2 + 61'sd524288;
	assign sh_c  = rnd_c >>> 20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			coef_q <= '0;
		else if (coef_we)
			coef_q <= coef_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1  <= (POLY_W+1)'(p_in) + (POLY_W+1)'(coef_q);
			r2_s1   <= r2_in;
			side_s1 <= side_in;

			prod_s2 <= sum_s1 * $signed({1'b0, r2_s1});
			r2_s2   <= r2_s1;
			side_s2 <= side_s1;

			p_s3    <= sat32(64'(sh_c));
			r2_s3   <= r2_s2;
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign p_out     = p_s3;
	assign r2_out    = r2_s3;
	assign side_out  = side_s3;

endmodule

`default_nettype wire

// ===== rtl/core/rdr_back.sv =====
// Back end: displacement d*p, recentring, saturation and the inside test.
// Three register stages advancing on adv; inside flag is combinational. Depends on rdr_pkg.
`default_nettype none

module rdr_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             adv,
	input  wire logic                             in_valid,
	input  wire logic signed [rdr_pkg::POLY_W-1:0] p_in,
	input  wire rdr_pkg::side_t                   side_in,
	input  wire logic [rdr_pkg::CTR_W-1:0]         center_x,
	input  wire logic [rdr_pkg::CTR_W-1:0]         center_y,
	input  wire logic [rdr_pkg::SIDE_W-1:0]        width_cl,
	input  wire logic [rdr_pkg::SIDE_W-1:0]        height_cl,
	output logic                                  out_valid,
	output logic signed [rdr_pkg::CRD_W-1:0]       src_x,
	output logic signed [rdr_pkg::CRD_W-1:0]       src_y,
	output logic                                  in_image
);
	import rdr_pkg::*;

	logic v_s1, v_s2, v_s3;
	side_t side_s1, side_s2;
	logic signed [52:0] mx_s1, my_s1;
	logic signed [32:0] disp_x_s2, disp_y_s2;
	logic signed [CRD_W-1:0] sx_s3, sy_s3;

	logic signed [52:0] rnd_x_c, rnd_y_c, sh_x_c, sh_y_c;
	logic signed [35:0] sum_x_c, sum_y_c;

	assign rnd_x_c = mx_s1 + 53'sd524288;
	assign rnd_y_c = my_s1 + 53'sd524288;
	assign sh_x_c  = rnd_x_c >>> 20;
	assign sh_y_c  = rnd_y_c >>> 20;

	assign sum_x_c = 36'($signed({1'b0, side_s2.pix_x, 8'b0})) + 36'(disp_x_s2)
		- 36'($signed({1'b0, width_cl, 7'b0})) + 36'($signed({1'b0, center_x}));
	assign sum_y_c = 36'($signed({1'b0, side_s2.pix_y, 8'b0})) + 36'(disp_y_s2)
		- 36'($signed({1'b0, height_cl, 7'b0})) + 36'($signed({1'b0, center_y}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1   <= $signed(side_in.dx) * p_in;
			my_s1   <= $signed(side_in.dy) * p_in;
			side_s1 <= side_in;

			disp_x_s2 <= sh_x_c[32:0];
			disp_y_s2 <= sh_y_c[32:0];
			side_s2   <= side_s1;

			sx_s3 <= sat24(64'(sum_x_c));
			sy_s3 <= sat24(64'(sum_y_c));
		end
	end

	// Lower bound of -1 pixel matches truncation toward zero downstream.
	assign in_image = (sx_s3 > -24'sd256) && (sy_s3 > -24'sd256)
		&& (25'(sx_s3) < $signed({4'b0, width_cl, 8'b0}))
		&& (25'(sy_s3) < $signed({4'b0, height_cl, 8'b0}));

	assign out_valid = v_s3;
	assign src_x     = sx_s3;
	assign src_y     = sy_s3;

endmodule

`default_nettype wire

// ===== rtl/core/radial_distortion_remap.sv =====
// Radial lens distortion remap, Brown model with up to three radial terms.
// Pipeline: five front stages, three per Horner cell, three back stages, output register.
// Throughput: one item per cycle; every stage advances together whenever the output register
// is empty or its result transfers, so a held result freezes the whole chain.
// Reset: asynchronous, active low; clears stage valids and loads register defaults.
`default_nettype none

module radial_distortion_remap #(
	parameter int NUM_RADIAL_TERMS = rdr_pkg::NUM_TERMS_DEF,
	parameter int MAX_IMAGE_SIDE   = rdr_pkg::MAX_SIDE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	rdr_pix_if.sink                           pix,
	rdr_src_if.source                         src,
	input  wire logic                         cfg_we,
	input  wire logic [rdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rdr_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import rdr_pkg::*;

	// Configuration registers; the coefficients live in the cells.
	logic [CTR_W-1:0]  center_x_q, center_y_q;
	logic [INVF_W-1:0] inv_focal_q;
	logic [SIDE_W-1:0] width_q, height_q;
	logic [SIDE_W-1:0] width_cl, height_cl;

	// Global advance: the chain moves when the output register can take a result.
	logic adv;

	logic out_valid_q;
	logic signed [CRD_W-1:0] src_x_q, src_y_q;
	logic inside_q;

	// Cell chain links; link 0 is fed by the front end.
	logic                     v_chain    [NUM_RADIAL_TERMS+1];
	logic signed [POLY_W-1:0] p_chain    [NUM_RADIAL_TERMS+1];
	logic [R2_W-1:0]          r2_chain   [NUM_RADIAL_TERMS+1];
	side_t                    side_chain [NUM_RADIAL_TERMS+1];

	logic bk_valid;
	logic signed [CRD_W-1:0] bk_src_x, bk_src_y;
	logic bk_inside;

	assign adv       = !out_valid_q || src.ready;
	assign pix.ready = adv;

	// Clamp the image sides to the largest supported side.
	assign width_cl  = (width_q > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE) : width_q;
	assign height_cl = (height_q > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= 20'd524288;
			center_y_q  <= 20'd524288;
			inv_focal_q <= 24'd16384;
			width_q     <= 13'd4096;
			height_q    <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:     center_x_q  <= cfg_wdata[CTR_W-1:0];
				REG_CENTER_Y:     center_y_q  <= cfg_wdata[CTR_W-1:0];
				REG_INV_FOCAL:    inv_focal_q <= cfg_wdata[INVF_W-1:0];
				REG_IMAGE_WIDTH:  width_q     <= cfg_wdata[SIDE_W-1:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_wdata[SIDE_W-1:0];
				REG_COEF_K1, REG_COEF_K2, REG_COEF_K3: ;
			endcase
		end
	end

	// Offset, normalization and squared radius.
	rdr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pix.valid),
		.pixel_x   (pix.pixel_x),
		.pixel_y   (pix.pixel_y),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.inv_focal (inv_focal_q),
		.out_valid (v_chain[0]),
		.r2        (r2_chain[0]),
		.side      (side_chain[0])
	);

	assign p_chain[0] = '0;

	// Horner chain: the first cell holds the highest-order term, the last holds k1.
	for (genvar j = 0; j < NUM_RADIAL_TERMS; j++) begin : g_cell
		logic coef_we;

		assign coef_we = cfg_we && (cfg_index == coef_reg(NUM_RADIAL_TERMS - 1 - j));

		rdr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.coef_we    (coef_we),
			.coef_wdata (cfg_wdata[COEF_W-1:0]),
			.in_valid   (v_chain[j]),
			.p_in       (p_chain[j]),
			.r2_in      (r2_chain[j]),
			.side_in    (side_chain[j]),
			.out_valid  (v_chain[j+1]),
			.p_out      (p_chain[j+1]),
			.r2_out     (r2_chain[j+1]),
			.side_out   (side_chain[j+1])
		);
	end

	// Displacement, recentring and bounds. The final r2 is dropped here.
	rdr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_chain[NUM_RADIAL_TERMS]),
		.p_in      (p_chain[NUM_RADIAL_TERMS]),
		.side_in   (side_chain[NUM_RADIAL_TERMS]),
		.center_x  (center_x_q),
		.center_y  (center_y_q),
		.width_cl  (width_cl),
		.height_cl (height_cl),
		.out_valid (bk_valid),
		.src_x     (bk_src_x),
		.src_y     (bk_src_y),
		.in_image  (bk_inside)
	);

	// Output register: hold the result until it transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= bk_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_x_q  <= bk_src_x;
			src_y_q  <= bk_src_y;
			inside_q <= bk_inside;
		end
	end

	assign src.valid      = out_valid_q;
	assign src.src_x      = src_x_q;
	assign src.src_y      = src_y_q;
	assign src.inside_res = inside_q;

	// An inside result never lies at or left of / above -1 pixel.
	a_inside_lower: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && inside_q |-> (src_x_q > -24'sd256) && (src_y_q > -24'sd256))
		else $error("inside flag set on a position below -1 pixel");

	// A stalled chain keeps its last stage.
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(bk_valid))
		else $error("back stage moved during a stall");

	// A result appears only from a valid back stage.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(bk_valid))
		else $error("result valid without a back-stage item");

endmodule

`default_nettype wire
